### hdl/rsabc_pkg.sv
`default_nettype none
package rsabc_pkg;
    localparam int KeyBits   = 64;
    localparam int DigitBits = 16;
    localparam int MaxUnits  = 4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_EXPONENT = 2'd0;
    localparam logic [1:0] CFG_MODULUS  = 2'd1;
    localparam logic [1:0] CFG_CPB      = 2'd2;

    // One closed block handed from the front end to the engine.
    typedef struct packed {
        logic [63:0] block;
        logic [2:0]  size;
        logic        eom;
    } job_t;

    // Block size with out-of-range codes clamped.
    function automatic logic [2:0] clamp_size(input logic [2:0] k);
        logic [2:0] r;
        begin
            r = k;
            if (k == 3'd0) r = 3'd1;
            else if (k > 3'd4) r = 3'd4;
            return r;
        end
    endfunction
endpackage
`default_nettype wire

### hdl/rsabc_front.sv
`default_nettype none
// Packs code units into blocks and queues closed blocks for the engine.
module rsabc_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [15:0]       code_unit,
    input  wire logic              eom,
    input  wire logic [2:0]        cpb,
    output logic                   job_valid,
    input  wire logic              job_ready,
    output rsabc_pkg::job_t        job
);
    logic [63:0] acc_reg, acc_next;
    logic [2:0]  cnt_reg, cnt_next;
    // Two-entry queue.
    rsabc_pkg::job_t q_reg [2];
    logic [1:0]  fill_reg;
    logic        rd_reg, wr_reg;
    logic        close, push, pop;
    logic [2:0]  k;

    assign k        = rsabc_pkg::clamp_size(cpb);
    assign in_ready = (fill_reg != 2'd2);
    assign acc_next = {acc_reg[47:0], code_unit};
    assign cnt_next = cnt_reg + 3'd1;
    assign close    = eom || (cnt_next >= k);
    assign push     = in_valid && in_ready && close;
    assign job_valid = (fill_reg != 2'd0);
    assign pop      = job_valid && job_ready;
    assign job      = q_reg[rd_reg];

    // Accumulator and queue bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            cnt_reg  <= '0;
            fill_reg <= '0;
            rd_reg   <= 1'b0;
            wr_reg   <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                acc_reg <= close ? '0 : acc_next;
                cnt_reg <= close ? '0 : cnt_next;
            end
            if (push) begin
                q_reg[wr_reg] <= '{block: acc_next, size: k, eom: eom};
                wr_reg <= ~wr_reg;
            end
            if (pop) rd_reg <= ~rd_reg;
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

### hdl/rsabc_engine.sv
`default_nettype none
// Square-and-multiply with a bit-serial modular multiplier, then digit output.
module rsabc_engine (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              job_valid,
    output logic                   job_ready,
    input  wire rsabc_pkg::job_t   job,
    input  wire logic [63:0]       exponent,
    input  wire logic [63:0]       modulus,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [15:0]            out_unit,
    output logic                   no_char,
    output logic                   last_of_block,
    output logic                   last_of_message
);
    localparam logic [2:0] S_IDLE = 3'd0, S_RED = 3'd1, S_EXP = 3'd2, S_MUL = 3'd3,
                           S_EMIT = 3'd4;
    localparam logic [1:0] M_RES = 2'd1, M_SQR = 2'd2;

    logic [2:0]  st_reg;
    logic [1:0]  mk_reg;
    logic [63:0] n_reg, e_reg, base_reg, res_reg, acc_reg, ma_reg, mb_reg;
    logic [6:0]  bit_reg;
    logic [2:0]  k_reg, idx_reg;
    logic        eom_reg;
    logic        ov_reg;
    logic [15:0] ou_reg;
    logic        nc_reg, lb_reg, lm_reg;
    // One shift-add step: acc = 2*acc (+ a) mod n.
    logic [64:0] dbl, dsub, ad, asub;
    logic [63:0] acc1, acc2;
    logic [2:0]  digits;
    logic [63:0] sh;
    logic        load_out;

    assign dbl  = {acc_reg, 1'b0};
    assign dsub = dbl - {1'b0, n_reg};
    assign acc1 = dsub[64] ? dbl[63:0] : dsub[63:0];
    assign ad   = {1'b0, acc1} + {1'b0, ma_reg};
    assign asub = ad - {1'b0, n_reg};
    assign acc2 = mb_reg[63] ? (asub[64] ? ad[63:0] : asub[63:0]) : acc1;

    always_comb begin
        digits = (res_reg[63:48] != 0) ? 3'd4 : (res_reg[47:32] != 0) ? 3'd3 :
                 (res_reg[31:16] != 0) ? 3'd2 : 3'd1;
    end
    assign sh = res_reg >> {idx_reg[1:0], 4'd0};

    // The output register takes a new item only once the previous one has gone.
    assign load_out = ((st_reg == S_EMIT) ||
                       ((st_reg == S_EXP) && (e_reg == 64'd0) && (res_reg == 64'd0)))
                      && (!ov_reg || out_ready);

    assign job_ready = (st_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign out_unit = ou_reg;
    assign no_char = nc_reg;
    assign last_of_block = lb_reg;
    assign last_of_message = lm_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end else begin
            ov_reg <= load_out || (ov_reg && !out_ready);
            case (st_reg)
                S_IDLE: if (job_valid) begin
                    n_reg <= modulus; e_reg <= exponent;
                    k_reg <= job.size; eom_reg <= job.eom;
                    // Reduce the block modulo n, one block bit per cycle.
                    ma_reg <= 64'd0; mb_reg <= job.block; acc_reg <= '0;
                    bit_reg <= 7'd64; st_reg <= S_RED;
                end
                S_RED: begin
                    // Plain shift-subtract reduction: acc = 2acc+bit mod n.
                    if (n_reg < 64'd2) begin
                        res_reg <= '0; e_reg <= '0; st_reg <= S_EXP;
                    end else if (bit_reg == 7'd0) begin
                        base_reg <= acc_reg; res_reg <= 64'd1; st_reg <= S_EXP;
                    end else begin
                        acc_reg <= mb_reg[63] ? ((acc1 + 64'd1 >= n_reg) ?
                                   acc1 + 64'd1 - n_reg : acc1 + 64'd1) : acc1;
                        mb_reg <= mb_reg << 1;
                        bit_reg <= bit_reg - 7'd1;
                    end
                end
                S_EXP: begin
                    if (e_reg == 64'd0) begin
                        if (res_reg == 64'd0) begin
                            if (load_out) begin
                                ou_reg <= '0; nc_reg <= 1'b1; lb_reg <= 1'b1;
                                lm_reg <= eom_reg; st_reg <= S_IDLE;
                            end
                        end else begin
                            idx_reg <= ((digits < k_reg) ? digits : k_reg) - 3'd1;
                            st_reg <= S_EMIT;
                        end
                    end else begin
                        acc_reg <= '0; bit_reg <= 7'd64;
                        if (e_reg[0]) begin
                            mk_reg <= M_RES; ma_reg <= res_reg; mb_reg <= base_reg;
                        end else begin
                            mk_reg <= M_SQR; ma_reg <= base_reg; mb_reg <= base_reg;
                        end
                        st_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (bit_reg == 7'd0) begin
                        acc_reg <= '0; bit_reg <= 7'd64;
                        if (mk_reg == M_RES) begin
                            res_reg <= acc_reg; mk_reg <= M_SQR;
                            ma_reg <= base_reg; mb_reg <= base_reg;
                        end else begin
                            base_reg <= acc_reg; e_reg <= e_reg >> 1; st_reg <= S_EXP;
                        end
                    end else begin
                        acc_reg <= acc2; mb_reg <= mb_reg << 1;
                        bit_reg <= bit_reg - 7'd1;
                    end
                end
                S_EMIT: if (load_out) begin
                    ou_reg <= sh[15:0]; nc_reg <= 1'b0;
                    lb_reg <= (idx_reg == 3'd0);
                    lm_reg <= (idx_reg == 3'd0) && eom_reg;
                    idx_reg <= idx_reg - 3'd1;
                    if (idx_reg == 3'd0) st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### hdl/rsa_block_cipher_utf16.sv
`default_nettype none
// RSA block transform over 16-bit code units. Units are packed into blocks of
// chars_per_block; each closed block is raised to the exponent modulo the modulus
// with a bit-serial shift-add multiplier, one bit per cycle; each exponent bit
// takes a square, preceded by a multiply when the bit is set. A two-entry queue
// lets input continue while the engine works. Configure only while idle.
module rsa_block_cipher_utf16 (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // code_unit
    input  wire logic        s_tlast,   // end_of_message
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // out_unit
    output logic [1:0]       m_tuser,   // no_char, last_of_block
    output logic             m_tlast,   // last_of_message
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [63:0] cfg_wdata
);
    logic [63:0] exp_reg, mod_reg;
    logic [2:0]  cpb_reg;
    logic        jv, jr;
    rsabc_pkg::job_t job;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_reg <= '0; mod_reg <= 64'd2; cpb_reg <= 3'd1;
        end else if (cfg_we) begin
            case (cfg_addr)
                rsabc_pkg::CFG_EXPONENT: exp_reg <= cfg_wdata;
                rsabc_pkg::CFG_MODULUS:  mod_reg <= cfg_wdata;
                rsabc_pkg::CFG_CPB:      cpb_reg <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    rsabc_front u_front (.aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready),
        .code_unit(s_tdata), .eom(s_tlast), .cpb(cpb_reg),
        .job_valid(jv), .job_ready(jr), .job(job));

    rsabc_engine u_engine (.aclk, .aresetn, .job_valid(jv), .job_ready(jr), .job(job),
        .exponent(exp_reg), .modulus(mod_reg), .out_valid(m_tvalid),
        .out_ready(m_tready), .out_unit(m_tdata), .no_char(m_tuser[0]),
        .last_of_block(m_tuser[1]), .last_of_message(m_tlast));
endmodule
`default_nettype wire

### hdl/rsabc_checker.sv
`default_nettype none
// Port-level checks.
module rsabc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);
    // Marker items carry a zero digit and close the block.
    a_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 16'd0 && m_tuser[1]) else $error("marker");
    // End of message only on the last item of a block.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[1]) else $error("last");
    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("hold");
endmodule

bind rsa_block_cipher_utf16 rsabc_checker u_chk (.aclk, .aresetn, .m_tvalid,
    .m_tready, .m_tdata, .m_tuser, .m_tlast);
`default_nettype wire
